// ----- rtl/skf_pkg.sv -----
// ----------------------------------------------------------------------------
// skf_pkg: shared types and constants of the scalar Kalman filter
// Holds the channel payloads, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package skf_pkg;

  localparam int DATA_W     = 32;
  localparam int DEN_W      = DATA_W + 1;
  localparam int MUL_AW     = DATA_W + 2;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 1'd1;

  localparam logic [DATA_W-1:0] PROCESS_NOISE_RESET = 32'd65536;
  localparam logic [DATA_W-1:0] MEASURE_NOISE_RESET = 32'd98304;

  typedef struct packed {
    logic              channel;
    logic [DATA_W-1:0] sample;
  } meas_t;

  typedef struct packed {
    logic              out_channel;
    logic [DATA_W-1:0] estimate;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DIV_GO,
    ST_DIV,
    ST_MUL_EST,
    ST_MUL_VAR,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic in_rdy;
    logic ld_pred;
    logic div_go;
    logic ld_kg;
    logic mul_en;
    logic mul_var;
    logic ld_xnew;
  } ctl_t;

endpackage

`default_nettype wire

// ----- rtl/skf_stream_if.sv -----
// ----------------------------------------------------------------------------
// skf_stream_if: valid/ready stream channel
// Carries one payload beat per cycle when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface skf_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/scalar_kalman_filter_top.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_filter_top: multi-channel scalar Kalman filter, fixed point
// Per-channel estimate and variance; gain from an iterative divider, updates
// from one shared multiplier, all steps run by a small sequencer.
// ----------------------------------------------------------------------------
// Flow: an accepted measurement beat passes through predict, the one-bit-per-cycle
//   gain divider (FRAC_BITS + 1 steps), two passes through the multiplier and
//   the commit before the result beat.
// Busy while working: the next beat is taken only once the sequencer is back
//   in idle, and a result still held on the output stalls the commit.
// Reset: synchronous, active high; clears all estimates and variances to zero
//   and loads Q = 1.0 and R = 1.5 (at FRAC_BITS = 16).
`default_nettype none

module scalar_kalman_filter_top
  import skf_pkg::*;
#(
  parameter int NUM_CHANNELS = 2,
  parameter int FRAC_BITS    = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  skf_stream_if.sink                meas,
  skf_stream_if.source              result,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data
);

  localparam int KW   = FRAC_BITS + 1;
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [KW-1:0] ONE = KW'(1) << FRAC_BITS;

  // Configuration registers.
  logic [DATA_W-1:0] process_noise;
  logic [DATA_W-1:0] measure_noise;

  // Per-channel filter state.
  logic [DATA_W-1:0] est_value    [NUM_CHANNELS];
  logic [DATA_W-1:0] err_variance [NUM_CHANNELS];

  // Sequencer.
  state_t state, state_next;
  ctl_t   ctl;

  // Working registers of the item in flight.
  logic              ch_in;
  logic [CH_W-1:0]   ch_idx;
  logic [DATA_W-1:0] sample;
  logic [DATA_W-1:0] x_old;
  logic [DATA_W-1:0] p;
  logic [DEN_W-1:0]  den;
  logic [KW-1:0]     kg;
  logic [DATA_W-1:0] x_new;

  // Output register.
  logic              out_valid;
  logic              out_channel;
  logic [DATA_W-1:0] estimate;

  // Shared units.
  logic                     div_done;
  logic [KW-1:0]            div_quot;
  logic signed [MUL_AW-1:0] mul_a;
  logic [KW-1:0]            mul_b;
  logic signed [MUL_AW+KW:0] prod;

  // Prediction path.
  logic [DEN_W-1:0]  var_sum;
  logic [DATA_W-1:0] p_pred;
  logic [CH_W-1:0]   ch_sel;
  logic              out_free;
  logic              commit;

  // --------------------------------------------------------------------------
  // Configuration writes; indexes past the list are dropped.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise <= PROCESS_NOISE_RESET;
      measure_noise <= MEASURE_NOISE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROCESS_NOISE: process_noise <= cfg_data;
        REG_MEASURE_NOISE: measure_noise <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer: next state.
  // --------------------------------------------------------------------------
  assign out_free = ~out_valid | result.ready;
  assign commit   = (state == ST_COMMIT) && out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (meas.valid) state_next = ST_PRED;
      ST_PRED:    state_next = ST_DIV_GO;
      ST_DIV_GO:  state_next = ST_DIV;
      ST_DIV:     if (div_done) state_next = ST_MUL_EST;
      ST_MUL_EST: state_next = ST_MUL_VAR;
      ST_MUL_VAR: state_next = ST_COMMIT;
      ST_COMMIT:  if (out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Sequencer: per-state controls.
  always_comb begin
    ctl = '0;
    case (state)
      ST_IDLE:    ctl.in_rdy  = 1'b1;
      ST_PRED:    ctl.ld_pred = 1'b1;
      ST_DIV_GO:  ctl.div_go  = 1'b1;
      ST_DIV:     ctl.ld_kg   = div_done;
      ST_MUL_EST: ctl.mul_en  = 1'b1;
      ST_MUL_VAR: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_var = 1'b1;
        ctl.ld_xnew = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign meas.ready = ctl.in_rdy;

  // --------------------------------------------------------------------------
  // Capture the measurement; clamp channels past the last one.
  // --------------------------------------------------------------------------
  assign ch_sel = (32'(meas.data.channel) >= NUM_CHANNELS) ?
                  CH_W'(NUM_CHANNELS - 1) : CH_W'(meas.data.channel);

  always_ff @(posedge clk) begin
    if (meas.valid && ctl.in_rdy) begin
      ch_in  <= meas.data.channel;
      ch_idx <= ch_sel;
      sample <= meas.data.sample;
    end
  end

  // --------------------------------------------------------------------------
  // Predict: p = variance + Q, saturated; denominator p + R at 33 bits.
  // --------------------------------------------------------------------------
  assign var_sum = {1'b0, err_variance[ch_idx]} + {1'b0, process_noise};
  assign p_pred  = var_sum[DATA_W] ? '1 : var_sum[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.ld_pred) begin
      p     <= p_pred;
      den   <= {1'b0, p_pred} + {1'b0, measure_noise};
      x_old <= est_value[ch_idx];
    end
  end

  // --------------------------------------------------------------------------
  // Gain k = (p << F) / (p + R); zero when the denominator is zero.
  // --------------------------------------------------------------------------
  skf_div #(
    .QW (KW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.div_go),
    .num   ({1'b0, p}),
    .den   (den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (ctl.ld_kg) begin
      kg <= (den == '0) ? '0 : div_quot;
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier: first k * (sample - estimate), then (1 - k) * p.
  // --------------------------------------------------------------------------
  always_comb begin
    if (ctl.mul_var) begin
      mul_a = $signed({2'b00, p});
      mul_b = ONE - kg;
    end else begin
      mul_a = $signed({{2{sample[DATA_W-1]}}, sample}) -
              $signed({{2{x_old[DATA_W-1]}}, x_old});
      mul_b = kg;
    end
  end

  skf_mul #(
    .BW (KW)
  ) u_mul (
    .clk  (clk),
    .en   (ctl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Arithmetic shift by F keeps the low word of the delta; add it modulo 2^32.
  always_ff @(posedge clk) begin
    if (ctl.ld_xnew) begin
      x_new <= x_old + prod[FRAC_BITS +: DATA_W];
    end
  end

  // --------------------------------------------------------------------------
  // Commit: write back channel state and load the output register together.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        est_value[i]    <= '0;
        err_variance[i] <= '0;
      end
    end else if (commit) begin
      est_value[ch_idx]    <= x_new;
      err_variance[ch_idx] <= prod[FRAC_BITS +: DATA_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_channel <= ch_in;
      estimate    <= x_new;
    end
  end

  assign result.valid            = out_valid;
  assign result.data.out_channel = out_channel;
  assign result.data.estimate    = estimate;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  a_gain_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL_EST |-> kg <= ONE)
    else $error("gain above one");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    commit |=> result.valid)
    else $error("committed result not presented");

  a_accept_starts_predict: assert property (@(posedge clk) disable iff (rst)
    meas.valid && meas.ready |=> state == ST_PRED)
    else $error("accepted beat did not start a prediction");

  a_no_accept_when_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !meas.ready)
    else $error("ready raised while an item is in flight");

endmodule

`default_nettype wire

// ----- rtl/skf_div.sv -----
// ----------------------------------------------------------------------------
// skf_div: restoring divider, one quotient bit per cycle
// Computes floor((num << (QW-1)) / den) for num <= den, QW bits of quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_div
  import skf_pkg::*;
#(
  parameter int QW = 17
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DEN_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [QW-1:0]         quot
);

  localparam int CW = $clog2(QW + 1);

  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt;
  logic             run;

  logic [DEN_W+1:0] sub;
  logic             ge;
  logic [DEN_W:0]   rem_sel;

  assign sub     = {1'b0, rem} - {2'b00, den_q};
  assign ge      = ~sub[DEN_W+1];
  assign rem_sel = ge ? sub[DEN_W:0] : rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(QW - 1);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, num};
      den_q <= den;
      quot  <= '0;
    end else if (run) begin
      rem  <= {rem_sel[DEN_W-1:0], 1'b0};
      quot <= {quot[QW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/skf_mul.sv -----
// ----------------------------------------------------------------------------
// skf_mul: shared registered multiplier
// Signed operand times unsigned operand, product registered when enabled.
// ----------------------------------------------------------------------------
`default_nettype none

module skf_mul
  import skf_pkg::*;
#(
  parameter int BW = 17
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [MUL_AW-1:0] a,
  input  wire logic        [BW-1:0]     b,
  output logic signed [MUL_AW+BW:0]     prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= a * $signed({1'b0, b});
    end
  end

endmodule

`default_nettype wire
